/* src/vsc_pkg.sv */
// Package for the voxel store with column sky light.
// Holds command codes, cell word layout and default sizing; no dependencies.
package vsc_pkg;

  localparam int EDGE_DEF = 32;

  localparam logic [1:0] CMD_PLACE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CONT  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // A stored cell is {lit, block kind}.
  localparam int KIND_W = 8;
  localparam int CELL_W = KIND_W + 1;

  typedef logic [CELL_W-1:0] cell_t;

endpackage

/* src/vsc_cell_ram.sv */
// Cell memory of the voxel store: one write port, one registered read port.
// Depends on vsc_pkg for the cell word type.
module vsc_cell_ram
  import vsc_pkg::*;
#(
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [0:(1 << AW)-1];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/voxel_store_column_light_unit.sv */
// Top level of the voxel store with column sky light.
// Depends on vsc_pkg and instantiates vsc_cell_ram.
//
// A cubic store of EDGE^3 cells, each holding a block kind and a sky-lit bit in one
// synchronous memory. A request is taken when start is high and busy is low; its single
// result appears on the out_ ports for exactly one cycle, marked by out_valid, and the
// receiver cannot stall it. After reset the block clears the whole memory (air, lit),
// one entry per cycle, holding busy high until every entry is cleared; the configuration
// port is open throughout. Out-of-range requests (for a continue, x or z out of range), a
// continue whose top row lies below the floor and the unknown command are answered
// straight from the idle state; a continue with y above the top starts at the top row. A
// read passes through its read and output states. A place reads the cell, writes it and
// then walks the column below, and a continue walks the column directly; each walked cell
// costs a memory read state and a check-and-write state on the single read port.
// The result strobe comes while busy is low (in the cycle busy falls if it rose), so the
// next request may be accepted in the same cycle a result is shown.
module voxel_store_column_light_unit
  import vsc_pkg::*;
#(
  parameter int EDGE = EDGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_command,
  input  logic signed [7:0]   in_pos_x,
  input  logic signed [7:0]   in_pos_y,
  input  logic signed [7:0]   in_pos_z,
  input  logic [KIND_W-1:0]   in_block_kind,
  input  logic                in_light_in,
  // result channel
  output logic                out_valid,
  output logic                out_accepted,
  output logic [KIND_W-1:0]   out_block_out,
  output logic                out_lit_out,
  output logic                out_pass_down,
  output logic                out_pass_light,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_is_bottom_chunk
);

  localparam int CW = (EDGE > 1) ? $clog2(EDGE) : 1;
  localparam int AW = 3 * CW;
  localparam logic [7:0] EDGE_B = 8'(EDGE);
  localparam logic [CW-1:0] TOP_ROW = CW'(EDGE - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PRD  = 3'd2;
  localparam logic [2:0] S_PWR  = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_ROUT = 3'd5;
  localparam logic [2:0] S_WRD  = 3'd6;
  localparam logic [2:0] S_WCHK = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]     x_r, x_nxt;
  logic [CW-1:0]     y_r, y_nxt;
  logic [CW-1:0]     z_r, z_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              walk_lit_r, walk_lit_nxt;
  logic              is_place_r, is_place_nxt;
  logic              bottom_r, bottom_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic [KIND_W-1:0] out_block_r, out_block_nxt;
  logic              out_lit_r, out_lit_nxt;
  logic              out_pd_r, out_pd_nxt;
  logic              out_pl_r, out_pl_nxt;

  // Memory port signals.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_rdata;
  logic [AW-1:0] cur_addr;

  logic x_ok, y_ok, z_ok;

  // A signed coordinate is in range when, read as unsigned, it is below EDGE; negative
  // values land at 128 and above, beyond any supported edge.
  assign x_ok = (in_pos_x < EDGE_B);
  assign y_ok = (in_pos_y < EDGE_B);
  assign z_ok = (in_pos_z < EDGE_B);

  assign cur_addr = {z_r, y_r, x_r};

  vsc_cell_ram #(
    .AW (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The configuration register may be written at any time; the user writes it only
  // while the block is idle.
  assign cfg_ready  = 1'b1;
  assign bottom_nxt = (cfg_valid && cfg_ready) ? cfg_is_bottom_chunk : bottom_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    kind_nxt      = kind_r;
    walk_lit_nxt  = walk_lit_r;
    is_place_nxt  = is_place_r;
    out_valid_nxt = 1'b0;
    out_acc_nxt   = 1'b0;
    out_block_nxt = '0;
    out_lit_nxt   = 1'b0;
    out_pd_nxt    = 1'b0;
    out_pl_nxt    = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cur_addr;
    mem_wdata     = mem_rdata;
    mem_raddr     = cur_addr;

    case (state_r)
      S_CLR: begin
        // Reset pass: every cell becomes air and lit.
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = {1'b1, {KIND_W{1'b0}}};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          x_nxt        = in_pos_x[CW-1:0];
          y_nxt        = in_pos_y[CW-1:0];
          z_nxt        = in_pos_z[CW-1:0];
          kind_nxt     = in_block_kind;
          is_place_nxt = (in_command == CMD_PLACE);
          case (in_command)
            CMD_PLACE: begin
              if (x_ok && y_ok && z_ok) begin
                state_nxt = S_PRD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            CMD_READ: begin
              if (x_ok && y_ok && z_ok) begin
                state_nxt = S_RRD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            CMD_CONT: begin
              walk_lit_nxt = in_light_in;
              if (!(x_ok && z_ok)) begin
                out_valid_nxt = 1'b1;
              end else if (in_pos_y[7]) begin
                // Empty walk: the request runs straight off the bottom.
                out_valid_nxt = 1'b1;
                out_pd_nxt    = !bottom_r;
                out_pl_nxt    = !bottom_r && in_light_in;
              end else begin
                if (!y_ok) begin
                  y_nxt = TOP_ROW;
                end
                state_nxt = S_WRD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_PRD: begin
        // Read of the placed cell is in flight.
        state_nxt = S_PWR;
      end

      S_PWR: begin
        // Write the new kind, keep the cell's lit bit, and start the walk below, or finish if the cell is on row 0.
        mem_we       = 1'b1;
        mem_wdata    = {mem_rdata[KIND_W], kind_r};
        walk_lit_nxt = (kind_r == '0) ? mem_rdata[KIND_W] : 1'b0;
        if (y_r == '0) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b1;
          out_pd_nxt    = !bottom_r;
          out_pl_nxt    = !bottom_r && (kind_r == '0) && mem_rdata[KIND_W];
        end else begin
          y_nxt     = y_r - 1'b1;
          state_nxt = S_WRD;
        end
      end

      S_RRD: begin
        state_nxt = S_ROUT;
      end

      S_ROUT: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_block_nxt = mem_rdata[KIND_W-1:0];
        out_lit_nxt   = mem_rdata[KIND_W];
      end

      S_WRD: begin
        // Read of the current column cell is in flight.
        state_nxt = S_WCHK;
      end

      S_WCHK: begin
        if (mem_rdata[KIND_W] == walk_lit_r) begin
          // Cell already holds the value: the walk ends here.
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_acc_nxt   = is_place_r;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {walk_lit_r, mem_rdata[KIND_W-1:0]};
          if (mem_rdata[KIND_W-1:0] != '0) begin
            // An occupied cell takes the value and stops the walk.
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_acc_nxt   = is_place_r;
          end else if (y_r == '0) begin
            // Ran past the floor of this chunk.
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_acc_nxt   = is_place_r;
            out_pd_nxt    = !bottom_r;
            out_pl_nxt    = !bottom_r && walk_lit_r;
          end else begin
            y_nxt     = y_r - 1'b1;
            state_nxt = S_WRD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      bottom_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      bottom_r    <= bottom_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers carry no reset.
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    kind_r      <= kind_nxt;
    walk_lit_r  <= walk_lit_nxt;
    is_place_r  <= is_place_nxt;
    out_acc_r   <= out_acc_nxt;
    out_block_r <= out_block_nxt;
    out_lit_r   <= out_lit_nxt;
    out_pd_r    <= out_pd_nxt;
    out_pl_r    <= out_pl_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_block_out  = out_block_r;
  assign out_lit_out    = out_lit_r;
  assign out_pass_down  = out_pd_r;
  assign out_pass_light = out_pl_r;

endmodule

/* src/vsc_checker.sv */
// Port-level checker for the voxel store with column sky light, bound to the top level.
// Depends on vsc_pkg for the command codes.
module vsc_checker
  import vsc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [1:0]        in_command,
  input logic signed [7:0] in_pos_x,
  input logic              out_valid,
  input logic              out_accepted,
  input logic [KIND_W-1:0] out_block_out,
  input logic              out_lit_out,
  input logic              out_pass_down,
  input logic              out_pass_light
);

  // A light value is only handed down together with a pass-down request.
  a_pl_needs_pd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pass_light |-> out_pass_down)
    else $error("pass_light without pass_down");

  // A placed block never reports read data.
  a_place_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> (out_block_out == '0) && !out_lit_out)
    else $error("place result carries read data");

  // The unknown command is answered at once with an all-zero result (pass_light unchecked).
  a_none_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_NONE) |=>
      out_valid && !out_accepted && (out_block_out == '0) && !out_lit_out &&
      !out_pass_down)
    else $error("unknown command not answered with zeros");

  // A read with a negative x is answered at once with air and unlit.
  a_read_oob: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_READ) && in_pos_x[7] |=>
      out_valid && (out_block_out == '0) && !out_lit_out)
    else $error("out-of-range read not answered with air");

endmodule

bind voxel_store_column_light_unit vsc_checker u_vsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_command     (in_command),
  .in_pos_x       (in_pos_x),
  .out_valid      (out_valid),
  .out_accepted   (out_accepted),
  .out_block_out  (out_block_out),
  .out_lit_out    (out_lit_out),
  .out_pass_down  (out_pass_down),
  .out_pass_light (out_pass_light)
);
